// ===== rtl/stable_priority_message_queue_assert.svh =====
// assertion macros for the stable priority message queue
`ifndef STABLE_PRIORITY_MESSAGE_QUEUE_ASSERT_SVH
`define STABLE_PRIORITY_MESSAGE_QUEUE_ASSERT_SVH
`ifndef SYNTH
// same-cycle implication
`define SPMQ_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define SPMQ_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define SPMQ_ASSERT_IMP(lbl, ante, cons, msg)
`define SPMQ_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

// ===== rtl/spmq_pkg.sv =====
// shared types and codes of the stable priority message queue
package spmq_pkg;

  localparam int FUNC_W   = 2;
  localparam int TAG_W    = 32;
  localparam int PRIO_W   = 8;
  localparam int STATUS_W = 2;
  localparam int FILL_W   = 5;

  localparam logic [FUNC_W-1:0] FUNC_WRITE = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_CLEAN = 2'd2;

  localparam logic [STATUS_W-1:0] STATUS_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

  // control broadcast to every cell
  typedef struct packed {
    logic push;
    logic pop;
    logic by_prio;
  } cell_ctl_t;

endpackage

// ===== rtl/spmq_if.sv =====
// valid/ready channels of the stable priority message queue
interface spmq_in_if;
  import spmq_pkg::*;
  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [TAG_W-1:0]  msg_tag;
  logic [PRIO_W-1:0] msg_priority;
  logic              ordered;

  modport source (output valid, func, msg_tag, msg_priority, ordered, input ready);
  modport sink (input valid, func, msg_tag, msg_priority, ordered, output ready);
endinterface

interface spmq_out_if;
  import spmq_pkg::*;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic                head_valid;
  logic [TAG_W-1:0]    head_tag;
  logic [PRIO_W-1:0]   head_priority;
  logic [FILL_W-1:0]   fill_count;

  modport source (output valid, status, head_valid, head_tag, head_priority, fill_count,
                  input ready);
  modport sink (input valid, status, head_valid, head_tag, head_priority, fill_count,
                output ready);
endinterface

// ===== rtl/spmq_cell.sv =====
// one queue slot: holds an entry and shifts with its neighbors
module spmq_cell #(
  parameter int TAG_BITS  = 32,
  parameter int PRIO_BITS = 8
) (
  input  logic                  clk,
  input  spmq_pkg::cell_ctl_t   ctl,
  input  logic                  occupied,
  input  logic                  at_tail,
  input  logic                  found_in,
  output logic                  found_out,
  input  logic [TAG_BITS-1:0]   new_tag,
  input  logic [PRIO_BITS-1:0]  new_prio,
  input  logic [TAG_BITS-1:0]   left_tag,
  input  logic [PRIO_BITS-1:0]  left_prio,
  input  logic [TAG_BITS-1:0]   right_tag,
  input  logic [PRIO_BITS-1:0]  right_prio,
  output logic [TAG_BITS-1:0]   tag_q,
  output logic [PRIO_BITS-1:0]  prio_q
);
  import spmq_pkg::*;

  logic [TAG_BITS-1:0]  tag_r, tag_nxt;
  logic [PRIO_BITS-1:0] prio_r, prio_nxt;
  logic                 gt;

  // first strictly greater entry from the head takes the new word
  assign gt        = ctl.by_prio && occupied && (prio_r > new_prio);
  assign found_out = found_in | gt;

  always_comb begin
    tag_nxt  = tag_r;
    prio_nxt = prio_r;
    if (ctl.push) begin
      if (found_in) begin
        tag_nxt  = left_tag;
        prio_nxt = left_prio;
      end else if (gt || at_tail) begin
        tag_nxt  = new_tag;
        prio_nxt = new_prio;
      end
    end else if (ctl.pop) begin
      tag_nxt  = right_tag;
      prio_nxt = right_prio;
    end
  end

  always_ff @(posedge clk) begin
    tag_r  <= tag_nxt;
    prio_r <= prio_nxt;
  end

  assign tag_q  = tag_r;
  assign prio_q = prio_r;

endmodule

// ===== rtl/stable_priority_message_queue.sv =====
// stable priority message queue: a row of shifting cells plus a result register
//
// in_ch takes one word per operation: func selects write, read head or clean.
// A write appends at the tail, or with ordered set goes in front of the first
// entry from the head whose priority is strictly greater; a write to a full
// queue is dropped with status full. A read pops the head, or reports empty.
// out_ch returns one word per operation with status, the popped entry and
// the fill count after the operation.
// The result word appears on out_ch in the cycle after acceptance, and one
// operation is taken every cycle unless stalled: all cells compare against the
// new priority at once; the insertion point ripples along the cells in that cycle.
// The result sits in an output register; a new word is accepted while the
// pending result is taken in the same cycle. When the receiver stalls, the
// result holds and in_ch.ready drops until it is taken.
// Reset empties the queue and the result register; entry contents are not
// cleared, only the fill count.
module stable_priority_message_queue #(
  parameter int QUEUE_DEPTH = 16,
  parameter int PRIO_BITS   = 8,
  parameter int TAG_BITS    = 32
) (
  input logic          clk,
  input logic          rst_n,
  spmq_in_if.sink      in_ch,
  spmq_out_if.source   out_ch
);
  import spmq_pkg::*;

  localparam int OCC_W = $clog2(QUEUE_DEPTH + 1);

  logic [OCC_W-1:0]     occ_r, occ_nxt;
  logic                 out_valid_r;
  logic [STATUS_W-1:0]  status_r, status_nxt;
  logic                 head_valid_r, head_valid_nxt;
  logic [TAG_W-1:0]     head_tag_r, head_tag_nxt;
  logic [PRIO_W-1:0]    head_prio_r, head_prio_nxt;
  logic [FILL_W-1:0]    fill_r;

  logic                 in_fire;
  logic                 full;
  logic                 empty;
  cell_ctl_t            ctl;
  logic [TAG_BITS-1:0]  new_tag;
  logic [PRIO_BITS-1:0] new_prio;

  logic [QUEUE_DEPTH:0]  found;
  logic [TAG_BITS-1:0]   cell_tag  [QUEUE_DEPTH];
  logic [PRIO_BITS-1:0]  cell_prio [QUEUE_DEPTH];

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign full        = (occ_r == OCC_W'(QUEUE_DEPTH));
  assign empty       = (occ_r == '0);
  assign new_tag     = TAG_BITS'(in_ch.msg_tag);
  assign new_prio    = PRIO_BITS'(in_ch.msg_priority);

  always_comb begin
    ctl            = '0;
    ctl.by_prio    = in_ch.ordered;
    occ_nxt        = occ_r;
    status_nxt     = STATUS_DONE;
    head_valid_nxt = 1'b0;
    head_tag_nxt   = '0;
    head_prio_nxt  = '0;
    unique case (in_ch.func)
      FUNC_WRITE: begin
        if (full) begin
          status_nxt = STATUS_FULL;
        end else begin
          ctl.push = in_fire;
          occ_nxt  = occ_r + 1'b1;
        end
      end
      FUNC_READ: begin
        if (empty) begin
          status_nxt = STATUS_EMPTY;
        end else begin
          ctl.pop        = in_fire;
          occ_nxt        = occ_r - 1'b1;
          head_valid_nxt = 1'b1;
          head_tag_nxt   = TAG_W'(cell_tag[0]);
          head_prio_nxt  = PRIO_W'(cell_prio[0]);
        end
      end
      FUNC_CLEAN: begin
        occ_nxt = '0;
      end
      default: begin
      end
    endcase
  end

  assign found[0] = 1'b0;

  for (genvar k = 0; k < QUEUE_DEPTH; k++) begin : g_cell
    logic [TAG_BITS-1:0]  left_tag, right_tag;
    logic [PRIO_BITS-1:0] left_prio, right_prio;

    if (k == 0) begin : g_head
      assign left_tag  = new_tag;
      assign left_prio = new_prio;
    end else begin : g_mid
      assign left_tag  = cell_tag[k-1];
      assign left_prio = cell_prio[k-1];
    end

    if (k == QUEUE_DEPTH - 1) begin : g_last
      assign right_tag  = cell_tag[k];
      assign right_prio = cell_prio[k];
    end else begin : g_inner
      assign right_tag  = cell_tag[k+1];
      assign right_prio = cell_prio[k+1];
    end

    spmq_cell #(
      .TAG_BITS  (TAG_BITS),
      .PRIO_BITS (PRIO_BITS)
    ) u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .occupied   (occ_r > OCC_W'(k)),
      .at_tail    (occ_r == OCC_W'(k)),
      .found_in   (found[k]),
      .found_out  (found[k+1]),
      .new_tag    (new_tag),
      .new_prio   (new_prio),
      .left_tag   (left_tag),
      .left_prio  (left_prio),
      .right_tag  (right_tag),
      .right_prio (right_prio),
      .tag_q      (cell_tag[k]),
      .prio_q     (cell_prio[k])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        occ_r       <= occ_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result word payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      status_r     <= status_nxt;
      head_valid_r <= head_valid_nxt;
      head_tag_r   <= head_tag_nxt;
      head_prio_r  <= head_prio_nxt;
      fill_r       <= FILL_W'(occ_nxt);
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.status        = status_r;
  assign out_ch.head_valid    = head_valid_r;
  assign out_ch.head_tag      = head_tag_r;
  assign out_ch.head_priority = head_prio_r;
  assign out_ch.fill_count    = fill_r;

`include "stable_priority_message_queue_assert.svh"

  `SPMQ_ASSERT_IMP(a_occ_bound, 1'b1, occ_r <= OCC_W'(QUEUE_DEPTH), "occupancy above depth")
  `SPMQ_ASSERT_NXT(a_pop_count, in_fire && in_ch.func == FUNC_READ && !empty,
                   occ_r == OCC_W'($past(occ_r) - 1'b1), "pop did not decrement")
  `SPMQ_ASSERT_NXT(a_drop_full, in_fire && in_ch.func == FUNC_WRITE && full,
                   status_r == STATUS_FULL && $stable(occ_r), "full write not dropped")
  `SPMQ_ASSERT_IMP(a_head_done, out_valid_r && head_valid_r, status_r == STATUS_DONE,
                   "popped entry with bad status")

endmodule

// ===== dv/testbench.sv =====
// testbench for the stable priority message queue: shadow queue, random traffic and stalls
`timescale 1ns / 1ps

module testbench;
  import spmq_pkg::*;

  localparam int QUEUE_DEPTH   = 16;
  localparam int RANDOM_ITEMS  = 400;
  localparam int STALL_LIMIT   = 2000;
  localparam int HOLD_CYCLES   = 48;
  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [TAG_W-1:0]  tag;
    logic [PRIO_W-1:0] prio;
    logic              ordered;
  } op_t;

  typedef struct packed {
    logic [TAG_W-1:0]  tag;
    logic [PRIO_W-1:0] prio;
  } entry_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                head_valid;
    logic [TAG_W-1:0]    head_tag;
    logic [PRIO_W-1:0]   head_priority;
    logic [FILL_W-1:0]   fill_count;
  } word_t;

  // mirror of the queue contents plus the words still owed by the block
  class spmq_shadow;
    entry_t shadow_entries[$];
    word_t  owed_words[$];
    int     errors;

    function new();
      errors = 0;
    endfunction

    task report_mismatch(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    function int pending();
      return owed_words.size();
    endfunction

    task apply_op(op_t op);
      word_t  w;
      entry_t e;
      int     pos;
      w = '0;
      w.status = STATUS_DONE;
      case (op.func)
        FUNC_WRITE: begin
          if (shadow_entries.size() >= QUEUE_DEPTH) begin
            w.status = STATUS_FULL;
          end else begin
            e.tag  = op.tag;
            e.prio = op.prio;
            pos = shadow_entries.size();
            if (op.ordered) begin
              // first entry with a strictly greater priority, so ties keep order
              for (int k = 0; k < shadow_entries.size(); k++) begin
                if (shadow_entries[k].prio > op.prio) begin
                  pos = k;
                  break;
                end
              end
            end
            shadow_entries.insert(pos, e);
          end
        end
        FUNC_READ: begin
          if (shadow_entries.size() == 0) begin
            w.status = STATUS_EMPTY;
          end else begin
            e = shadow_entries.pop_front();
            w.head_valid    = 1'b1;
            w.head_tag      = e.tag;
            w.head_priority = e.prio;
          end
        end
        FUNC_CLEAN: begin
          shadow_entries.delete();
        end
        default: begin
        end
      endcase
      w.fill_count = FILL_W'(shadow_entries.size());
      owed_words.push_back(w);
    endtask

    task compare_field(string name, logic [63:0] got, logic [63:0] want);
      if (got !== want)
        report_mismatch($sformatf("%s got 0x%0h expected 0x%0h", name, got, want));
    endtask

    task check_word(word_t got);
      word_t want;
      if (owed_words.size() == 0) begin
        report_mismatch($sformatf("unexpected word 0x%0h", got));
      end else begin
        want = owed_words.pop_front();
        compare_field("status", 64'(got.status), 64'(want.status));
        compare_field("head_valid", 64'(got.head_valid), 64'(want.head_valid));
        compare_field("head_tag", 64'(got.head_tag), 64'(want.head_tag));
        compare_field("head_priority", 64'(got.head_priority), 64'(want.head_priority));
        compare_field("fill_count", 64'(got.fill_count), 64'(want.fill_count));
      end
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n;

  spmq_in_if  in_ch();
  spmq_out_if out_ch();

  spmq_shadow board = new();

  logic src_steady;
  logic sink_steady;
  logic hold_request;
  int   hold_left;
  int   quiet_cycles;

  always #1 clk = ~clk;

  stable_priority_message_queue #(
    .QUEUE_DEPTH(QUEUE_DEPTH),
    .PRIO_BITS  (PRIO_W),
    .TAG_BITS   (TAG_W)
  ) dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  task automatic send_op(input op_t op);
    // idle cycle by cycle so about a third of the cycles carry no word
    while (!src_steady && $urandom_range(99) < 35) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.func         <= op.func;
    in_ch.msg_tag      <= op.tag;
    in_ch.msg_priority <= op.prio;
    in_ch.ordered      <= op.ordered;
    do @(posedge clk); while (!in_ch.ready);
    board.apply_op(op);
  endtask

  function automatic op_t make_op(logic [FUNC_W-1:0] func, logic [TAG_W-1:0] tag,
                                  logic [PRIO_W-1:0] prio, logic ordered);
    op_t op;
    op.func    = func;
    op.tag     = tag;
    op.prio    = prio;
    op.ordered = ordered;
    return op;
  endfunction

  // burst flavor: 0 fills, 1 drains, 2 mixes in cleans and the unused code
  function automatic op_t random_op(int flavor);
    int   pick;
    op_t  op;
    pick = $urandom_range(99);
    op.tag = $urandom;
    // few distinct priorities half the time so ties are common
    op.prio = ($urandom_range(1) == 1) ? PRIO_W'($urandom_range(3)) : PRIO_W'($urandom_range(255));
    op.ordered = ($urandom_range(99) < 75);
    case (flavor)
      0: op.func = (pick < 85) ? FUNC_WRITE : FUNC_READ;
      1: op.func = (pick < 85) ? FUNC_READ : FUNC_WRITE;
      default: begin
        if (pick < 50)      op.func = FUNC_WRITE;
        else if (pick < 90) op.func = FUNC_READ;
        else if (pick < 95) op.func = FUNC_CLEAN;
        else                op.func = FUNC_UNUSED;
      end
    endcase
    return op;
  endfunction

  // result side: check accepted words, then choose the next ready
  initial begin
    bit hold_taken;
    out_ch.ready <= 1'b0;
    hold_left = 0;
    hold_taken = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready)
        board.check_word({out_ch.status, out_ch.head_valid, out_ch.head_tag,
                          out_ch.head_priority, out_ch.fill_count});
      if (hold_request && !hold_taken) begin
        hold_left = HOLD_CYCLES;
        hold_taken = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (sink_steady) begin
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= 35);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int  sent;
    int  flavor;
    int  burst;
    bit  held;
    bit  paused;
    rst_n              <= 1'b0;
    in_ch.valid        <= 1'b0;
    in_ch.func         <= FUNC_WRITE;
    in_ch.msg_tag      <= '0;
    in_ch.msg_priority <= '0;
    in_ch.ordered      <= 1'b0;
    src_steady   = 1'b0;
    sink_steady  = 1'b0;
    hold_request = 1'b0;
    held   = 1'b0;
    paused = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty read, field extremes, tie ordering, unused code, clean
    send_op(make_op(FUNC_READ, '0, '0, 1'b0));
    send_op(make_op(FUNC_WRITE, '0, '0, 1'b0));
    send_op(make_op(FUNC_WRITE, '1, '1, 1'b1));
    send_op(make_op(FUNC_WRITE, 32'h5555_aaaa, 8'h80, 1'b1));
    send_op(make_op(FUNC_WRITE, 32'haaaa_5555, 8'h80, 1'b1));
    send_op(make_op(FUNC_WRITE, 32'h0000_0001, 8'h00, 1'b1));
    send_op(make_op(FUNC_WRITE, 32'h8000_0000, 8'h01, 1'b0));
    send_op(make_op(FUNC_UNUSED, '1, '1, 1'b1));
    send_op(make_op(FUNC_READ, '1, '1, 1'b1));
    send_op(make_op(FUNC_READ, '0, '0, 1'b0));
    send_op(make_op(FUNC_CLEAN, '1, '1, 1'b1));
    send_op(make_op(FUNC_READ, '0, '0, 1'b0));
    send_op(make_op(FUNC_CLEAN, '0, '0, 1'b0));

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      flavor = $urandom_range(2);
      burst  = (flavor == 2) ? $urandom_range(4, 16) : $urandom_range(8, 24);
      repeat (burst) begin
        src_steady  = (sent >= 100 && sent < 180);
        sink_steady = (sent >= 100 && sent < 180);
        if (!held && sent >= 250) begin
          // receiver stops while operations keep coming, block backs up
          hold_request = 1'b1;
          held = 1'b1;
        end
        if (!paused && sent >= 320) begin
          paused = 1'b1;
          in_ch.valid <= 1'b0;
          do @(posedge clk); while (board.pending() != 0);
        end
        send_op(random_op(flavor));
        sent++;
      end
    end

    in_ch.valid <= 1'b0;
    do @(posedge clk); while (board.pending() != 0);
    repeat (4) @(posedge clk);
    if (board.pending() != 0)
      board.report_mismatch($sformatf("%0d words never arrived", board.pending()));
    if (board.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
